// File: src/tab_to_space_expander_macros.svh
// Assertion macros used by the verification file of the tab expander.
`ifndef TAB_TO_SPACE_EXPANDER_MACROS_SVH
`define TAB_TO_SPACE_EXPANDER_MACROS_SVH

// Checked on every edge, also in reset.
`define TSE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("tab expander check failed");

// Checked only outside reset.
`define TSE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tab expander check failed");

`endif

// File: src/tse_pkg.sv
// Shared constants, codes and types of the tab-to-space expander.
package tse_pkg;

    localparam int DEF_MAX_TAB_SIZE = 16;

    localparam int TAB_SIZE_W = 5;
    localparam logic [TAB_SIZE_W-1:0] TAB_SIZE_RESET = 5'd4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAB_SIZE      = 1'b0,
        REG_IGNORE_QUOTES = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    typedef struct packed {
        logic char_q;
        logic str_q;
        logic esc;
    } tse_flags_t;

endpackage

// File: src/tse_decode.sv
// Per-byte decision: next column, next quote/escape flags, result byte and count of further repeats.
module tse_decode import tse_pkg::*; #(
    parameter int CW  = 4,
    parameter int TSW = 5
) (
    input  logic [7:0]     text_byte,
    input  logic           start_of_text,
    input  logic [CW-1:0]  col,
    input  tse_flags_t     flags,
    input  logic [TSW-1:0] ts,
    input  logic           ignore_quotes,
    output logic [CW-1:0]  col_next,
    output tse_flags_t     flags_next,
    output logic [7:0]     out_byte,
    output logic [CW-1:0]  run_cnt
);
    localparam int W = TSW + 1;

    always_comb begin
        logic [CW-1:0] ph;
        tse_flags_t    f;
        logic [W-1:0]  ph_inc;
        logic [CW-1:0] col_inc;
        logic [W-1:0]  gap;
        logic          nl;
        logic          cq;
        logic          sq;

        ph = start_of_text ? '0 : col;
        f  = start_of_text ? '0 : flags;
        nl = (text_byte == CHAR_LF) || (text_byte == CHAR_CR);

        ph_inc  = W'(ph) + W'(1);
        col_inc = (ph_inc == W'(ts)) ? '0 : ph_inc[CW-1:0];
        gap     = W'(ts) - W'(ph) - W'(1);

        col_next   = col_inc;
        flags_next = f;
        out_byte   = text_byte;
        run_cnt    = '0;
        cq         = f.char_q;
        sq         = f.str_q;

        if (f.esc) begin
            flags_next.esc = 1'b0;
        end else begin
            flags_next.esc = (text_byte == CHAR_BACKSLASH);
            if (!ignore_quotes && !sq && text_byte == CHAR_SQUOTE) cq = ~cq;
            if (!ignore_quotes && !cq && text_byte == CHAR_DQUOTE) sq = ~sq;
            if (nl) cq = 1'b0;
            flags_next.char_q = cq;
            flags_next.str_q  = sq;
            if (!(cq || sq)) begin
                if (nl) begin
                    col_next = '0;
                end else if (text_byte == CHAR_TAB) begin
                    col_next = '0;
                    out_byte = CHAR_SPACE;
                    run_cnt  = gap[CW-1:0];
                end
            end
        end
    end
endmodule

// File: src/tse_out_stage.sv
// Result register: holds one byte and repeats it for the remaining count of a run.
module tse_out_stage #(
    parameter int CW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic [7:0]    load_byte,
    input  logic [CW-1:0] load_cnt,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic          m_tlast    // last_of_run
);
    logic          valid_reg;
    logic [7:0]    byte_reg;
    logic [CW-1:0] remain_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = (remain_reg == '0);
    assign free     = !valid_reg || (m_tready && remain_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (valid_reg && m_tready) begin
            if (remain_reg == '0) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= load_byte;
            remain_reg <= load_cnt;
        end else if (valid_reg && m_tready && remain_reg != '0) begin
            remain_reg <= remain_reg - CW'(1);
        end
    end
endmodule

// File: src/tab_to_space_expander.sv
// Top level of the tab-to-space expander: config registers, state and datapath wiring.
//
// Byte stream in, byte stream out. An ordinary byte (and any tab that is escaped or
// inside a '...' or "..." span) gives one result with m_tlast set. A tab outside
// quotes gives tab_size - column spaces, one per cycle from the result register
// while m_tready is high; m_tlast marks the last space. The next byte is accepted
// in the same cycle the last result of the previous one is taken, so the sustained
// rate is one result per cycle while m_tready is high. s_tuser starts a new text:
// column, quote spans and a pending escape are cleared before that byte. tab_size 0
// acts as 1 and values above MAX_TAB_SIZE act as MAX_TAB_SIZE. When tab_size is
// lowered to or below the current column, the column is reduced modulo the new size
// by one subtraction per cycle, and input is held off until it is below the new
// size. Configuration is to be written by the user only while the stream is idle;
// the block itself does not enforce it.
module tab_to_space_expander import tse_pkg::*; #(
    parameter int MAX_TAB_SIZE = DEF_MAX_TAB_SIZE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tuser,   // start_of_text
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast    // last_of_run
);
    // CW holds a column 0..MAX-1, TSW holds a tab size 1..MAX
    localparam int CW  = $clog2(MAX_TAB_SIZE);
    localparam int TSW = $clog2(MAX_TAB_SIZE + 1);

    logic [TAB_SIZE_W-1:0] tab_size_reg;
    logic                  ignore_quotes_reg;
    logic [TSW-1:0]        ts_eff;

    logic [CW-1:0]  col_reg;
    tse_flags_t     flags_reg;

    logic [CW-1:0]  dec_col;
    tse_flags_t     dec_flags;
    logic [7:0]     dec_byte;
    logic [CW-1:0]  dec_cnt;

    logic           out_free;
    logic           col_ok;
    logic           accept;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_size_reg      <= TAB_SIZE_RESET;
            ignore_quotes_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TAB_SIZE:      tab_size_reg      <= cfg_wdata[TAB_SIZE_W-1:0];
                REG_IGNORE_QUOTES: ignore_quotes_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective tab size: zero acts as 1, saturate at MAX_TAB_SIZE
    always_comb begin
        if (tab_size_reg == '0)
            ts_eff = TSW'(1);
        else if (32'(tab_size_reg) > 32'(MAX_TAB_SIZE))
            ts_eff = TSW'(MAX_TAB_SIZE);
        else
            ts_eff = TSW'(tab_size_reg);
    end

    // column must be below the tab size before a byte is taken
    assign col_ok   = (TSW'(col_reg) < ts_eff);
    assign s_tready = out_free && col_ok;
    assign accept   = s_tvalid && s_tready;

    tse_decode #(
        .CW  (CW),
        .TSW (TSW)
    ) u_decode (
        .text_byte     (s_tdata),
        .start_of_text (s_tuser),
        .col           (col_reg),
        .flags         (flags_reg),
        .ts            (ts_eff),
        .ignore_quotes (ignore_quotes_reg),
        .col_next      (dec_col),
        .flags_next    (dec_flags),
        .out_byte      (dec_byte),
        .run_cnt       (dec_cnt)
    );

    // column and quote state; reduce column after a tab size change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            flags_reg <= '0;
        end else if (accept) begin
            col_reg   <= dec_col;
            flags_reg <= dec_flags;
        end else if (!col_ok) begin
            col_reg   <= CW'(TSW'(col_reg) - ts_eff);
        end
    end

    tse_out_stage #(
        .CW (CW)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_byte (dec_byte),
        .load_cnt  (dec_cnt),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule

// File: src/tse_monitor.sv
// Port-level assertions for the tab-to-space expander, bound to the top level.
`include "tab_to_space_expander_macros.svh"

module tse_monitor import tse_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    // nothing is pending right after reset
    `TSE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)

    // a stalled result holds
    `TSE_ASSERT(a_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // only tab expansion produces runs longer than one
    `TSE_ASSERT(a_run_spaces, m_tvalid && m_tdata != CHAR_SPACE |-> m_tlast)

    // a non-tab byte comes out unchanged as a single result in the next cycle
    `TSE_ASSERT(a_pass,
        s_tvalid && s_tready && s_tdata != CHAR_TAB |=>
            m_tvalid && m_tlast && m_tdata == $past(s_tdata))

    // input is taken only when the current run is finished
    `TSE_ASSERT(a_ready_free, s_tready |-> !m_tvalid || (m_tready && m_tlast))
endmodule

bind tab_to_space_expander tse_monitor u_monitor (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
